@@ rtl/core/rgb_led_serial_encoder_defines.svh @@
// ----------------------------------------------------------------------------
// RGB LED serial encoder assertion macros
// Shared property shorthands for the encoder's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef RGB_LED_SERIAL_ENCODER_DEFINES_SVH
`define RGB_LED_SERIAL_ENCODER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RGBSE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RGBSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/rgbse_pkg.sv @@
// ----------------------------------------------------------------------------
// RGB LED serial encoder package
// Beat types, command and queue status types, phases and register codes.
// ----------------------------------------------------------------------------
package rgbse_pkg;

  localparam int unsigned TIME_W     = 10;
  localparam int unsigned TICK_W     = 16;
  localparam int unsigned BITS_W     = 5;
  localparam int unsigned WORD_W     = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Two-entry queue between the front and back parts.
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [BITS_W-1:0] NUM_BITS = BITS_W'(24);

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LATCH     = 3'd4;

  // Register reset values.
  localparam logic [TIME_W-1:0] ZERO_HIGH_RST = 10'd16;
  localparam logic [TIME_W-1:0] ZERO_LOW_RST  = 10'd34;
  localparam logic [TIME_W-1:0] ONE_HIGH_RST  = 10'd32;
  localparam logic [TIME_W-1:0] ONE_LOW_RST   = 10'd18;
  localparam logic [TICK_W-1:0] LATCH_RST     = 16'd3200;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_HIGH  = 2'd1,
    PH_LOW   = 2'd2,
    PH_LATCH = 2'd3
  } phase_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_item_t;

  typedef struct packed {
    logic line_level;
    logic ready_res;
    logic load_taken;
    logic frame_done;
  } out_item_t;

  // Classified command as it sits in the queue.
  typedef struct packed {
    logic              is_load;
    logic [WORD_W-1:0] word;
  } cmd_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } q_stat_t;

endpackage

@@ rtl/core/rgbse_front.sv @@
// ----------------------------------------------------------------------------
// RGB LED serial encoder front part
// Takes input beats, sorts them into load or tick commands and hands them on.
// ----------------------------------------------------------------------------
module rgbse_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rgbse_pkg::in_item_t in_data,
  input  rgbse_pkg::q_stat_t q_stat,
  output logic               q_push,
  output rgbse_pkg::cmd_t    q_cmd
);

  logic            valid_r;
  logic            valid_nxt;
  rgbse_pkg::cmd_t cmd_r;
  logic            accept;

  assign in_stall = valid_r && q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = valid_r && !q_stat.full;
  assign q_cmd    = cmd_r;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (q_push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // The pixel word is packed green, red, blue from the top down.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r.is_load <= in_data.kind;
      cmd_r.word    <= {in_data.green, in_data.red, in_data.blue};
    end
  end

endmodule

@@ rtl/core/rgbse_queue.sv @@
// ----------------------------------------------------------------------------
// RGB LED serial encoder command queue
// Short first-in first-out buffer between the front and back parts.
// ----------------------------------------------------------------------------
module rgbse_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rgbse_pkg::cmd_t    push_cmd,
  input  logic               pop,
  output rgbse_pkg::cmd_t    head_cmd,
  output rgbse_pkg::q_stat_t stat
);

  rgbse_pkg::cmd_t                     mem_r [rgbse_pkg::Q_DEPTH];
  logic [rgbse_pkg::Q_PTR_W-1:0]       wr_ptr_r;
  logic [rgbse_pkg::Q_PTR_W-1:0]       wr_ptr_nxt;
  logic [rgbse_pkg::Q_PTR_W-1:0]       rd_ptr_r;
  logic [rgbse_pkg::Q_PTR_W-1:0]       rd_ptr_nxt;
  logic [rgbse_pkg::Q_CNT_W-1:0]       count_r;
  logic [rgbse_pkg::Q_CNT_W-1:0]       count_nxt;

  assign stat.not_empty = (count_r != '0);
  assign stat.full      = (count_r == rgbse_pkg::Q_CNT_W'(rgbse_pkg::Q_DEPTH));
  assign head_cmd       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == rgbse_pkg::Q_PTR_W'(rgbse_pkg::Q_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == rgbse_pkg::Q_PTR_W'(rgbse_pkg::Q_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ rtl/core/rgbse_back.sv @@
// ----------------------------------------------------------------------------
// RGB LED serial encoder back part
// Runs the bit timing machine on queued commands and holds the result beat.
// ----------------------------------------------------------------------------
module rgbse_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  rgbse_pkg::cmd_t                      q_cmd,
  input  rgbse_pkg::q_stat_t                   q_stat,
  output logic                                 q_pop,
  input  logic                                 cfg_we,
  input  logic [rgbse_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rgbse_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output rgbse_pkg::out_item_t                 out_data
);

  logic [rgbse_pkg::TIME_W-1:0] zero_high_r;
  logic [rgbse_pkg::TIME_W-1:0] zero_low_r;
  logic [rgbse_pkg::TIME_W-1:0] one_high_r;
  logic [rgbse_pkg::TIME_W-1:0] one_low_r;
  logic [rgbse_pkg::TICK_W-1:0] latch_r;

  rgbse_pkg::phase_t            phase_r;
  rgbse_pkg::phase_t            phase_nxt;
  logic [rgbse_pkg::WORD_W-1:0] shift_r;
  logic [rgbse_pkg::WORD_W-1:0] shift_nxt;
  logic [rgbse_pkg::BITS_W-1:0] bits_r;
  logic [rgbse_pkg::BITS_W-1:0] bits_nxt;
  logic [rgbse_pkg::BITS_W-1:0] bits_dec;
  logic [rgbse_pkg::TICK_W-1:0] cnt_r;
  logic [rgbse_pkg::TICK_W-1:0] cnt_nxt;
  logic [rgbse_pkg::TICK_W-1:0] cnt_inc;
  logic [rgbse_pkg::TICK_W-1:0] limit;
  logic                         over;
  logic                         bit_one;

  logic                 out_valid_r;
  rgbse_pkg::out_item_t out_data_r;
  rgbse_pkg::out_item_t res;

  assign q_pop     = q_stat.not_empty && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Timing registers; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_high_r <= rgbse_pkg::ZERO_HIGH_RST;
      zero_low_r  <= rgbse_pkg::ZERO_LOW_RST;
      one_high_r  <= rgbse_pkg::ONE_HIGH_RST;
      one_low_r   <= rgbse_pkg::ONE_LOW_RST;
      latch_r     <= rgbse_pkg::LATCH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rgbse_pkg::CFG_ZERO_HIGH: zero_high_r <= cfg_data[rgbse_pkg::TIME_W-1:0];
        rgbse_pkg::CFG_ZERO_LOW:  zero_low_r  <= cfg_data[rgbse_pkg::TIME_W-1:0];
        rgbse_pkg::CFG_ONE_HIGH:  one_high_r  <= cfg_data[rgbse_pkg::TIME_W-1:0];
        rgbse_pkg::CFG_ONE_LOW:   one_low_r   <= cfg_data[rgbse_pkg::TIME_W-1:0];
        rgbse_pkg::CFG_LATCH:     latch_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign bit_one  = shift_r[rgbse_pkg::WORD_W-1];
  assign cnt_inc  = cnt_r + 1'b1;
  assign bits_dec = (bits_r != '0) ? bits_r - 1'b1 : bits_r;

  always_comb begin
    case (phase_r)
      rgbse_pkg::PH_HIGH:  limit = rgbse_pkg::TICK_W'(bit_one ? one_high_r : zero_high_r);
      rgbse_pkg::PH_LOW:   limit = rgbse_pkg::TICK_W'(bit_one ? one_low_r : zero_low_r);
      rgbse_pkg::PH_LATCH: limit = latch_r;
      default:             limit = '0;
    endcase
  end

  // A zero limit still ends the period after one tick.
  assign over = (cnt_inc >= limit);

  // Next state.
  always_comb begin
    phase_nxt = phase_r;
    shift_nxt = shift_r;
    bits_nxt  = bits_r;
    cnt_nxt   = cnt_r;
    if (q_cmd.is_load) begin
      if (phase_r == rgbse_pkg::PH_IDLE) begin
        shift_nxt = q_cmd.word;
        bits_nxt  = rgbse_pkg::NUM_BITS;
        cnt_nxt   = '0;
        phase_nxt = rgbse_pkg::PH_HIGH;
      end
    end else begin
      case (phase_r)
        rgbse_pkg::PH_HIGH: begin
          cnt_nxt = over ? '0 : cnt_inc;
          if (over) begin
            phase_nxt = rgbse_pkg::PH_LOW;
          end
        end
        rgbse_pkg::PH_LOW: begin
          cnt_nxt = over ? '0 : cnt_inc;
          if (over) begin
            shift_nxt = {shift_r[rgbse_pkg::WORD_W-2:0], 1'b0};
            bits_nxt  = bits_dec;
            phase_nxt = (bits_dec == '0) ? rgbse_pkg::PH_LATCH : rgbse_pkg::PH_HIGH;
          end
        end
        rgbse_pkg::PH_LATCH: begin
          cnt_nxt = over ? '0 : cnt_inc;
          if (over) begin
            phase_nxt = rgbse_pkg::PH_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  // Result fields.
  always_comb begin
    res.line_level = (phase_r == rgbse_pkg::PH_HIGH);
    res.ready_res  = (phase_nxt == rgbse_pkg::PH_IDLE);
    res.load_taken = q_cmd.is_load && (phase_r == rgbse_pkg::PH_IDLE);
    res.frame_done = !q_cmd.is_load && (phase_r == rgbse_pkg::PH_LATCH) && over;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= rgbse_pkg::PH_IDLE;
      shift_r     <= '0;
      bits_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r <= phase_nxt;
        shift_r <= shift_nxt;
        bits_r  <= bits_nxt;
        cnt_r   <= cnt_nxt;
      end
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= res;
    end
  end

endmodule

@@ rtl/core/rgb_led_serial_encoder.sv @@
// ----------------------------------------------------------------------------
// RGB LED serial encoder
// Single-wire pulse-width encoder for an addressable RGB LED. Every input
// beat returns exactly one result beat, in order. A load beat latches one
// pixel (green, red, blue, sent most significant bit first) and is taken
// only while the encoder is idle; a load refused while busy returns
// load_taken low and ready_res low. Each tick beat is one timing quantum:
// its result carries the line level for that tick. A 0 bit is high for
// zero_high_ticks then low for zero_low_ticks, a 1 bit uses the one_*
// pair, and after 24 bits the line stays low for latch_ticks, the last of
// which raises frame_done. The encoder accepts one beat per clock in steady
// state while the output is not stalled; a beat passes through the input
// register, the command queue and the output register. Write the timing
// registers only while the encoder is idle and drained.
// ----------------------------------------------------------------------------
`include "rgb_led_serial_encoder_defines.svh"

module rgb_led_serial_encoder (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  rgbse_pkg::in_item_t              in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output rgbse_pkg::out_item_t             out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rgbse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rgbse_pkg::CFG_DATA_W-1:0] cfg_data
);

  // The front part registers each beat and classifies it; the back part
  // runs the bit timing machine. The queue lets the input keep flowing for
  // a couple of beats while the output is stalled.
  logic               q_push;
  logic               q_pop;
  rgbse_pkg::cmd_t    push_cmd;
  rgbse_pkg::cmd_t    head_cmd;
  rgbse_pkg::q_stat_t q_stat;

  // Register writes are always taken.
  assign cfg_ready = 1'b1;

  rgbse_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  rgbse_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .stat     (q_stat)
  );

  rgbse_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_cmd     (head_cmd),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // A taken load always leaves the encoder busy.
  `RGBSE_ASSERT_NOW(a_load_busy, out_valid && out_data.load_taken, !out_data.ready_res, "load taken but idle")
  // The end of a frame returns to idle with the line low.
  `RGBSE_ASSERT_NOW(a_done_idle, out_valid && out_data.frame_done, out_data.ready_res && !out_data.line_level, "frame done not idle")
  // The back part never pops an empty queue.
  `RGBSE_ASSERT_NOW(a_pop_nonempty, q_pop, q_stat.not_empty, "pop from empty queue")
  // The front part never pushes into a full queue.
  `RGBSE_ASSERT_NOW(a_push_room, q_push, !q_stat.full, "push into full queue")

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RGB LED serial encoder testbench
// Drives load and tick beats into the encoder under random sender bursts and
// receiver stalls. A scoreboard class predicts every result beat from its own
// copy of the waveform state and the timing registers, and compares each
// returned beat field by field. The run samples the reset timing and the
// longest timing over the first part of a frame, reprograms the registers in
// the middle of a frame, and covers the shortest timing and many random short
// timings.
// ----------------------------------------------------------------------------
module tb;
  import rgbse_pkg::*;

  // Generous bound for about 900 beats, even with the longest sender gaps and
  // the heaviest stalls, plus the short drains between register settings.
  localparam int unsigned CYCLE_LIMIT = 200_000;

  // Number of random beats to send after the directed part.
  localparam int unsigned RANDOM_BEATS = 360;

  // The pipeline is the input register, the command queue and the output register; wait a bit longer once drained.
  localparam int unsigned SETTLE_CYCLES = 8;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the encoder's waveform state beat by beat and keeps the
  // line results it expects, oldest first.
  // --------------------------------------------------------------------------
  class line_scoreboard;
    logic [TIME_W-1:0] zero_hi;
    logic [TIME_W-1:0] zero_lo;
    logic [TIME_W-1:0] one_hi;
    logic [TIME_W-1:0] one_lo;
    logic [TICK_W-1:0] latch_len;

    logic [WORD_W-1:0] pixel_word;
    logic [BITS_W-1:0] bits_remaining;
    phase_t            ph;
    logic [TICK_W-1:0] ticks_spent;

    out_item_t   line_results[$];
    int unsigned failures;

    function new();
      zero_hi        = ZERO_HIGH_RST;
      zero_lo        = ZERO_LOW_RST;
      one_hi         = ONE_HIGH_RST;
      one_lo         = ONE_LOW_RST;
      latch_len      = LATCH_RST;
      pixel_word     = '0;
      bits_remaining = '0;
      ph             = PH_IDLE;
      ticks_spent    = '0;
      failures       = 0;
    endfunction

    // Unknown indexes are dropped; data is cut to the register width.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_ZERO_HIGH: zero_hi   = data[TIME_W-1:0];
        CFG_ZERO_LOW:  zero_lo   = data[TIME_W-1:0];
        CFG_ONE_HIGH:  one_hi    = data[TIME_W-1:0];
        CFG_ONE_LOW:   one_lo    = data[TIME_W-1:0];
        CFG_LATCH:     latch_len = data[TICK_W-1:0];
        default: ;
      endcase
    endfunction

    // Count one tick. A limit of zero still lets exactly one tick pass.
    function bit period_elapsed(logic [TICK_W-1:0] limit);
      ticks_spent = ticks_spent + 1'b1;
      return ticks_spent >= limit;
    endfunction

    function void note_beat(in_item_t beat);
      out_item_t want;
      logic      bit_is_one;
      want = '0;
      if (beat.kind) begin
        // A load reports the level held before it takes effect.
        want.line_level = (ph == PH_HIGH);
        if (ph == PH_IDLE) begin
          pixel_word     = {beat.green, beat.red, beat.blue};
          bits_remaining = NUM_BITS;
          ticks_spent    = '0;
          ph             = PH_HIGH;
          want.load_taken = 1'b1;
        end
      end else begin
        bit_is_one = pixel_word[WORD_W-1];
        case (ph)
          PH_HIGH: begin
            want.line_level = 1'b1;
            if (period_elapsed(bit_is_one ? one_hi : zero_hi)) begin
              ticks_spent = '0;
              ph          = PH_LOW;
            end
          end
          PH_LOW: begin
            if (period_elapsed(bit_is_one ? one_lo : zero_lo)) begin
              ticks_spent = '0;
              pixel_word  = pixel_word << 1;
              if (bits_remaining != '0) bits_remaining = bits_remaining - 1'b1;
              ph = (bits_remaining == '0) ? PH_LATCH : PH_HIGH;
            end
          end
          PH_LATCH: begin
            if (period_elapsed(latch_len)) begin
              ticks_spent     = '0;
              ph              = PH_IDLE;
              want.frame_done = 1'b1;
            end
          end
          default: ;
        endcase
      end
      want.ready_res = (ph == PH_IDLE);
      line_results.push_back(want);
    endfunction

    function void check_beat(out_item_t got);
      out_item_t want;
      if (line_results.size() == 0) begin
        $error("result beat %b arrived with nothing expected", got);
        failures++;
        return;
      end
      want = line_results.pop_front();
      if (got.line_level !== want.line_level) begin
        $error("line_level: expected %0b, got %0b", want.line_level, got.line_level);
        failures++;
      end
      if (got.ready_res !== want.ready_res) begin
        $error("ready_res: expected %0b, got %0b", want.ready_res, got.ready_res);
        failures++;
      end
      if (got.load_taken !== want.load_taken) begin
        $error("load_taken: expected %0b, got %0b", want.load_taken, got.load_taken);
        failures++;
      end
      if (got.frame_done !== want.frame_done) begin
        $error("frame_done: expected %0b, got %0b", want.frame_done, got.frame_done);
        failures++;
      end
    endfunction

    function bit busy();
      return ph != PH_IDLE;
    endfunction

    function int unsigned pending();
      return line_results.size();
    endfunction
  endclass

  line_scoreboard scoreboard = new();

  // Sender burst state shared by every call of send_beat.
  int unsigned burst_left = 0;
  bit          steady     = 1'b0;
  int unsigned beats_sent = 0;
  int unsigned cycle_count = 0;

  rgb_led_serial_encoder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // A hung handshake or a lost result ends up here.
  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb: FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Beat builders.
  // --------------------------------------------------------------------------

  // Mostly random colour bytes, with the all-zero and all-one cases common.
  function automatic logic [7:0] colour_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // The colour fields of a tick are don't-care, so they carry random noise.
  function automatic in_item_t tick_beat();
    return '{kind: 1'b0, red: 8'($urandom), green: 8'($urandom), blue: 8'($urandom)};
  endfunction

  function automatic in_item_t load_beat(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    return '{kind: 1'b1, red: r, green: g, blue: b};
  endfunction

  // Short random timing value; now and then zero, and junk in the upper bits
  // that the register has to drop.
  function automatic logic [CFG_DATA_W-1:0] short_period();
    logic [TIME_W-1:0] len;
    len = ($urandom_range(0, 7) == 0) ? '0 : TIME_W'($urandom_range(1, 4));
    return {6'($urandom), len};
  endfunction

  // --------------------------------------------------------------------------
  // Drivers. Everything is driven with nonblocking assignments right after a
  // rising edge; handshake inputs from the encoder are sampled at the falling
  // edge, where they are settled, and the beat counts as moved at the next
  // rising edge.
  // --------------------------------------------------------------------------

  // Send one input beat. The sender works in bursts; between bursts it may
  // drop valid for a few cycles. Valid is never lowered and raised in the
  // same step, and the payload holds while the encoder stalls.
  task automatic send_beat(input in_item_t beat);
    int unsigned gap;
    bit          moved;
    if (burst_left == 0) begin
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
      steady     = ($urandom_range(0, 4) == 0);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do begin
      @(negedge clk);
      moved = !in_stall;
      @(posedge clk);
    end while (!moved);
    scoreboard.note_beat(beat);
    burst_left--;
    beats_sent++;
  endtask

  // Keep ticking until the predicted waveform is back to idle. With nonzero
  // odds, loads are slipped in while busy so the refusal path gets hit.
  task automatic finish_frame(input int unsigned refuse_odds);
    while (scoreboard.busy()) begin
      if (refuse_odds != 0 && $urandom_range(1, refuse_odds) == 1)
        send_beat(load_beat(colour_byte(), colour_byte(), colour_byte()));
      else
        send_beat(tick_beat());
    end
  endtask

  // Stop sending and wait for every expected beat, then let the pipeline
  // settle before anything touches the registers.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (scoreboard.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write. cfg_valid is left high; the caller lowers it after
  // the last write of a group.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    bit moved;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do begin
      @(negedge clk);
      moved = cfg_ready;
      @(posedge clk);
    end while (!moved);
    scoreboard.write_reg(idx, data);
  endtask

  task automatic set_timing(input logic [CFG_DATA_W-1:0] zh, input logic [CFG_DATA_W-1:0] zl,
                            input logic [CFG_DATA_W-1:0] oh, input logic [CFG_DATA_W-1:0] ol,
                            input logic [CFG_DATA_W-1:0] lt);
    write_reg(CFG_ZERO_HIGH, zh);
    write_reg(CFG_ZERO_LOW, zl);
    write_reg(CFG_ONE_HIGH, oh);
    write_reg(CFG_ONE_LOW, ol);
    write_reg(CFG_LATCH, lt);
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: picks a stall mode for a stretch of cycles, then another. Modes
  // are no stall at all, light random stall, heavy random stall, and a strict
  // every-other-cycle pattern.
  // --------------------------------------------------------------------------
  initial begin : stall_pattern
    int unsigned mode;
    int unsigned span;
    bit          flip;
    out_stall <= 1'b0;
    flip = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 200);
      repeat (span) begin
        @(posedge clk);
        flip = ~flip;
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 9) < 6);
          default: out_stall <= flip;
        endcase
      end
    end
  end

  // Result monitor: a beat is taken at a rising edge with valid high and
  // stall low, both as seen at the falling edge before it.
  initial begin : result_monitor
    bit        fire;
    out_item_t seen;
    forever begin
      @(negedge clk);
      fire = rst_n && out_valid && !out_stall;
      seen = out_data;
      @(posedge clk);
      if (fire) scoreboard.check_beat(seen);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned random_start;
    int unsigned frames;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_ZERO_HIGH;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset timing: ticks while idle must leave the line low, then the first
    // bits of a frame with the power-up register values (two ones and part
    // of a zero) and a load refused in the middle of it.
    send_beat('{kind: 1'b0, red: 8'h00, green: 8'h00, blue: 8'h00});
    send_beat('{kind: 1'b0, red: 8'hFF, green: 8'hFF, blue: 8'hFF});
    send_beat(load_beat(8'h5A, 8'hC3, 8'h96));
    repeat (120) send_beat(tick_beat());
    send_beat(load_beat(8'h00, 8'h00, 8'h00));
    repeat (20) send_beat(tick_beat());
    drain_results();

    // Shortest timing. Writes to unused indexes must be ignored, zero acts
    // as a one-tick period, and upper data bits are dropped on the 10-bit
    // registers (0xFC01 becomes 1, 0xFC00 becomes 0). The frame still under
    // way picks up the new values on its next tick, and a period that has
    // already run past its new length ends there.
    for (int k = 1; k <= 3; k++) write_reg(CFG_IDX_W'(CFG_LATCH + k), 16'($urandom));
    set_timing(16'h0000, 16'hFC01, 16'h0001, 16'hFC00, 16'h0000);
    finish_frame(0);

    // All-ones pixel; a load refused in the high part reports level 1, and
    // one refused in the low part reports level 0.
    send_beat(load_beat(8'hFF, 8'hFF, 8'hFF));
    send_beat(load_beat(8'h00, 8'h00, 8'h00));
    send_beat(tick_beat());
    send_beat(load_beat(8'hFF, 8'h00, 8'hFF));
    finish_frame(0);
    send_beat(load_beat(8'h00, 8'h00, 8'h00));
    finish_frame(0);
    send_beat(load_beat(8'hFF, 8'h00, 8'hFF));
    finish_frame(0);
    send_beat(tick_beat());
    drain_results();

    // Longest timing: every register at its top value. The line has to stay
    // high well past any short period; the frame is then finished on a
    // short timing, so the first high part ends on the next tick.
    set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_beat(load_beat(8'h0F, 8'hA5, 8'hF0));
    repeat (60) send_beat(tick_beat());
    send_beat(load_beat(8'h11, 8'h22, 8'h33));
    drain_results();
    set_timing(16'h0002, 16'h0003, 16'h0003, 16'h0002, 16'h0004);
    finish_frame(0);
    drain_results();

    // Random part: short random timing per setting, a few frames each. Most
    // beats belong to well-formed frames; idle ticks and loads thrown in
    // while busy supply the noise.
    random_start = beats_sent;
    while (beats_sent - random_start < RANDOM_BEATS) begin
      set_timing(short_period(), short_period(), short_period(), short_period(),
                 16'($urandom_range(0, 24)));
      frames = $urandom_range(2, 4);
      repeat (frames) begin
        if (beats_sent - random_start >= RANDOM_BEATS) break;
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) send_beat(tick_beat());
        end
        send_beat(load_beat(colour_byte(), colour_byte(), colour_byte()));
        finish_frame(25);
      end
      drain_results();
    end

    // drain_results has already waited out the pipeline; anything still
    // expected here means a result went missing.
    if (scoreboard.failures == 0 && scoreboard.pending() == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule
